// ===== hw/rtl/ppad_pkg.sv =====
// Package for the polyline point-at-distance block.
// Holds field widths, request codes, datapath operation codes and the
// command and status types shared by the controller and the datapath.
package ppad_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned CoordW = 24;
  localparam int unsigned ReqW = 2;

  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [ReqW-1:0] REQ_APPEND = 2'd1;
  localparam logic [ReqW-1:0] REQ_QUERY  = 2'd2;

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned SqW = 2 * DiffW;
  localparam int unsigned SqrtIter = SqW / 2;
  localparam int unsigned ProdW = DiffW + CoordW;
  localparam int unsigned DivW = ProdW + 1;
  localparam int unsigned IterW = $clog2(DivW);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_REFUSE,
    OP_WRITE0,
    OP_RD_PREV,
    OP_APP_ABS,
    OP_APP_SQX,
    OP_APP_SQY,
    OP_SQRT_STEP,
    OP_APP_WRITE,
    OP_WALK_INIT,
    OP_WALK_RD,
    OP_WALK_CHK,
    OP_RD_A,
    OP_RD_B,
    OP_CAP_B,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ITP,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   coord_y;
  } dp_cmd_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            empty;
    logic            lt2;
    logic            full;
    logic            walk_end;
    logic            sqrt_last;
    logic            div_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/ppad_if.sv =====
// Handshake interfaces for the request and response channels.
// Depends on ppad_pkg for the field widths.
interface ppad_req_if;
  logic                                valid;
  logic                                ready;
  logic [ppad_pkg::ReqW-1:0]           req_type;
  logic signed [ppad_pkg::CoordW-1:0]  vertex_x;
  logic signed [ppad_pkg::CoordW-1:0]  vertex_y;
  logic [ppad_pkg::CoordW-1:0]         travelled;
  logic                                forward;

  modport source (output valid, req_type, vertex_x, vertex_y, travelled, forward,
                  input ready);
  modport sink (input valid, req_type, vertex_x, vertex_y, travelled, forward,
                output ready);
endinterface

interface ppad_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppad_pkg::CoordW-1:0]  pos_x;
  logic signed [ppad_pkg::CoordW-1:0]  pos_y;
  logic                                no_path;
  logic [ppad_pkg::CoordW-1:0]         path_total;
  logic                                append_refused;

  modport source (output valid, pos_x, pos_y, no_path, path_total, append_refused,
                  input ready);
  modport sink (input valid, pos_x, pos_y, no_path, path_total, append_refused,
                output ready);
endinterface

// ===== hw/rtl/ppad_ctrl.sv =====
// Controller state machine of the polyline point-at-distance block.
// Sequences the datapath through append, walk, divide and response steps.
// Depends on ppad_pkg.
module ppad_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ppad_pkg::dp_stat_t stat_i,
  output ppad_pkg::dp_cmd_t  cmd_o
);
  import ppad_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_APP_ABS  = 5'd2;
  localparam logic [4:0] S_APP_SQX  = 5'd3;
  localparam logic [4:0] S_APP_SQY  = 5'd4;
  localparam logic [4:0] S_SQRT     = 5'd5;
  localparam logic [4:0] S_APP_WR   = 5'd6;
  localparam logic [4:0] S_WALK_RD  = 5'd7;
  localparam logic [4:0] S_WALK_CHK = 5'd8;
  localparam logic [4:0] S_RD_A     = 5'd9;
  localparam logic [4:0] S_RD_B     = 5'd10;
  localparam logic [4:0] S_CAP_B    = 5'd11;
  localparam logic [4:0] S_MUL      = 5'd12;
  localparam logic [4:0] S_DINIT    = 5'd13;
  localparam logic [4:0] S_DIV      = 5'd14;
  localparam logic [4:0] S_ITP      = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;

  logic [4:0] state_q, state_d;
  logic       coord_q, coord_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    coord_d     = coord_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.coord_y = coord_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        case (stat_i.req)
          REQ_CLEAR: cmd_o.op = OP_CLEAR;
          REQ_APPEND: begin
            if (stat_i.full) begin
              cmd_o.op = OP_REFUSE;
            end else if (stat_i.empty) begin
              cmd_o.op = OP_WRITE0;
            end else begin
              cmd_o.op = OP_RD_PREV;
              state_d  = S_APP_ABS;
            end
          end
          REQ_QUERY: begin
            if (!stat_i.lt2) begin
              cmd_o.op = OP_WALK_INIT;
              state_d  = S_WALK_RD;
            end
          end
          default: cmd_o.op = OP_NONE;
        endcase
      end
      S_APP_ABS: begin
        cmd_o.op = OP_APP_ABS;
        state_d  = S_APP_SQX;
      end
      S_APP_SQX: begin
        cmd_o.op = OP_APP_SQX;
        state_d  = S_APP_SQY;
      end
      S_APP_SQY: begin
        cmd_o.op = OP_APP_SQY;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (stat_i.sqrt_last) state_d = S_APP_WR;
      end
      S_APP_WR: begin
        cmd_o.op = OP_APP_WRITE;
        state_d  = S_FIN;
      end
      S_WALK_RD: begin
        cmd_o.op = OP_WALK_RD;
        state_d  = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd_o.op = OP_WALK_CHK;
        state_d  = stat_i.walk_end ? S_RD_A : S_WALK_RD;
      end
      S_RD_A: begin
        cmd_o.op = OP_RD_A;
        state_d  = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.op = OP_RD_B;
        state_d  = S_CAP_B;
      end
      S_CAP_B: begin
        cmd_o.op = OP_CAP_B;
        coord_d  = 1'b0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (stat_i.div_last) state_d = S_ITP;
      end
      S_ITP: begin
        cmd_o.op = OP_ITP;
        if (coord_q) begin
          state_d = S_FIN;
        end else begin
          coord_d = 1'b1;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_FIN) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      coord_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      coord_q     <= coord_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/ppad_dp.sv =====
// Datapath of the polyline point-at-distance block: vertex and length
// memories, square root and divider iterations, walk and response registers.
// Depends on ppad_pkg.
module ppad_dp #(
  parameter int unsigned MaxVertices = ppad_pkg::MaxVerticesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ppad_pkg::dp_cmd_t                  cmd_i,
  output ppad_pkg::dp_stat_t                 stat_o,
  input  logic [ppad_pkg::ReqW-1:0]          req_type_i,
  input  logic signed [ppad_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [ppad_pkg::CoordW-1:0] vertex_y_i,
  input  logic [ppad_pkg::CoordW-1:0]        travelled_i,
  input  logic                               forward_i,
  output logic signed [ppad_pkg::CoordW-1:0] pos_x_o,
  output logic signed [ppad_pkg::CoordW-1:0] pos_y_o,
  output logic                               no_path_o,
  output logic [ppad_pkg::CoordW-1:0]        path_total_o,
  output logic                               append_refused_o
);
  import ppad_pkg::*;

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxVertices);
  localparam int unsigned ResW = DivW + 2;
  localparam logic signed [ResW-1:0] RMax = ResW'(2**(CoordW-1) - 1);
  localparam logic signed [ResW-1:0] RMin = ResW'(-(2**(CoordW-1)));

  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CoordW-1:0]        tot_q, tot_d;
  logic [ReqW-1:0]          req_q;
  logic signed [CoordW-1:0] vx_q, vy_q;
  logic [CoordW-1:0]        dist_q;
  logic                     fwd_q;

  logic [CoordW-1:0] mem_x [MaxVertices];
  logic [CoordW-1:0] mem_y [MaxVertices];
  logic [CoordW-1:0] mem_l [MaxVertices];
  logic              rd_en, we;
  logic [AW-1:0]     rd_addr;
  logic [CoordW-1:0] wl;
  logic [CoordW-1:0] xr_q, yr_q, lr_q;

  logic [DiffW-1:0]  ux_q, uy_q;
  logic [SqW-1:0]    sq_q, sr_q, sb_q, sq_rb, sq_len;
  logic [CoordW-1:0] seg_len;
  logic [CoordW:0]   tot_sum;

  logic [CW-1:0]     k_q, back_idx, last_k;
  logic [CoordW-1:0] acc_q, len_q, rem_q;
  logic [AW-1:0]     seg, seg_q, prev_idx, ia, ib;
  logic [CoordW:0]   walk_sum;
  logic              hit, last;

  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q, ca, cb;
  logic signed [DiffW-1:0]  dx, dy, dd;
  logic [DiffW-1:0]         dabs;
  logic                     neg_q;
  logic [ProdW-1:0]         mag_q;
  logic [DivW-1:0]          dq_q;
  logic [CoordW-1:0]        pr_q;
  logic [CoordW:0]          dtrial;
  logic                     dge;
  logic [IterW-1:0]         iter_q;
  logic signed [ResW-1:0]   rsum;
  logic signed [CoordW-1:0] rsat;

  logic signed [CoordW-1:0] px_q, py_q, ox_q, oy_q;
  logic                     ref_q, oref_q, onp_q;
  logic [CoordW-1:0]        otot_q;

  assign back_idx = cnt_q - k_q;
  assign seg      = fwd_q ? k_q[AW-1:0] : back_idx[AW-1:0];
  assign last_k   = cnt_q - CW'(1);
  assign prev_idx = last_k[AW-1:0];
  assign ia       = fwd_q ? seg_q - AW'(1) : seg_q;
  assign ib       = fwd_q ? seg_q : seg_q - AW'(1);
  assign walk_sum = {1'b0, acc_q} + {1'b0, lr_q};
  assign hit      = walk_sum >= {1'b0, dist_q};
  assign last     = k_q == last_k;

  assign dx = DiffW'(vx_q) - DiffW'(signed'(xr_q));
  assign dy = DiffW'(vy_q) - DiffW'(signed'(yr_q));

  assign sq_rb   = sr_q + sb_q;
  assign sq_len  = sr_q + SqW'(sq_q > sr_q);
  assign seg_len = (sq_len > SqW'({CoordW{1'b1}})) ? {CoordW{1'b1}} : sq_len[CoordW-1:0];
  assign tot_sum = {1'b0, tot_q} + {1'b0, seg_len};

  assign ca   = cmd_i.coord_y ? ay_q : ax_q;
  assign cb   = cmd_i.coord_y ? by_q : bx_q;
  assign dd   = DiffW'(cb) - DiffW'(ca);
  assign dabs = dd[DiffW-1] ? DiffW'(-dd) : DiffW'(dd);

  assign dtrial = {pr_q, dq_q[DivW-1]};
  assign dge    = dtrial >= {1'b0, len_q};

  always_comb begin
    if (neg_q) begin
      rsum = ResW'(ca) - signed'({2'b00, dq_q});
    end else begin
      rsum = ResW'(ca) + signed'({2'b00, dq_q});
    end
    if (len_q == '0) begin
      rsat = ca;
    end else if (rsum > RMax) begin
      rsat = {1'b0, {(CoordW-1){1'b1}}};
    end else if (rsum < RMin) begin
      rsat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      rsat = rsum[CoordW-1:0];
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = prev_idx;
    case (cmd_i.op)
      OP_RD_PREV: rd_en = 1'b1;
      OP_WALK_RD: begin
        rd_en   = 1'b1;
        rd_addr = seg;
      end
      OP_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = ia;
      end
      OP_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = ib;
      end
      default: rd_en = 1'b0;
    endcase
  end

  assign we = (cmd_i.op == OP_WRITE0) || (cmd_i.op == OP_APP_WRITE);
  assign wl = (cmd_i.op == OP_WRITE0) ? '0 : seg_len;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_x[cnt_q[AW-1:0]] <= vx_q;
      mem_y[cnt_q[AW-1:0]] <= vy_q;
      mem_l[cnt_q[AW-1:0]] <= wl;
    end
    if (rd_en) begin
      xr_q <= mem_x[rd_addr];
      yr_q <= mem_y[rd_addr];
      lr_q <= mem_l[rd_addr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    tot_d = tot_q;
    case (cmd_i.op)
      OP_CLEAR: begin
        cnt_d = '0;
        tot_d = '0;
      end
      OP_WRITE0: cnt_d = cnt_q + CW'(1);
      OP_APP_WRITE: begin
        cnt_d = cnt_q + CW'(1);
        tot_d = tot_sum[CoordW] ? {CoordW{1'b1}} : tot_sum[CoordW-1:0];
      end
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tot_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      tot_q <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q  <= req_type_i;
        vx_q   <= vertex_x_i;
        vy_q   <= vertex_y_i;
        dist_q <= travelled_i;
        fwd_q  <= forward_i;
        px_q   <= '0;
        py_q   <= '0;
        ref_q  <= 1'b0;
      end
      OP_REFUSE: ref_q <= 1'b1;
      OP_APP_ABS: begin
        ux_q <= dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
        uy_q <= dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
      end
      OP_APP_SQX: sq_q <= ux_q * ux_q;
      OP_APP_SQY: begin
        sq_q   <= sq_q + uy_q * uy_q;
        sr_q   <= '0;
        sb_q   <= SqW'(1) << (SqW - 2);
        iter_q <= '0;
      end
      OP_SQRT_STEP: begin
        if (sq_q >= sq_rb) begin
          sq_q <= sq_q - sq_rb;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q   <= sb_q >> 2;
        iter_q <= iter_q + IterW'(1);
      end
      OP_WALK_INIT: begin
        k_q   <= CW'(1);
        acc_q <= '0;
      end
      OP_WALK_CHK: begin
        if (hit || last) begin
          seg_q <= seg;
          len_q <= lr_q;
          if (!hit) acc_q <= walk_sum[CoordW-1:0];
        end else begin
          acc_q <= walk_sum[CoordW-1:0];
          k_q   <= k_q + CW'(1);
        end
      end
      OP_RD_B: begin
        ax_q <= xr_q;
        ay_q <= yr_q;
      end
      OP_CAP_B: begin
        bx_q  <= xr_q;
        by_q  <= yr_q;
        rem_q <= dist_q - acc_q;
      end
      OP_MUL: begin
        neg_q <= dd[DiffW-1];
        mag_q <= dabs * rem_q;
      end
      OP_DIV_INIT: begin
        dq_q   <= DivW'(mag_q) + DivW'(len_q >> 1);
        pr_q   <= '0;
        iter_q <= '0;
      end
      OP_DIV_STEP: begin
        pr_q   <= dge ? CoordW'(dtrial - {1'b0, len_q}) : dtrial[CoordW-1:0];
        dq_q   <= {dq_q[DivW-2:0], dge};
        iter_q <= iter_q + IterW'(1);
      end
      OP_ITP: begin
        if (cmd_i.coord_y) begin
          py_q <= rsat;
        end else begin
          px_q <= rsat;
        end
      end
      OP_FIN: begin
        ox_q   <= px_q;
        oy_q   <= py_q;
        oref_q <= ref_q;
        onp_q  <= cnt_q < CW'(2);
        otot_q <= tot_q;
      end
      default: iter_q <= iter_q;
    endcase
  end

  assign stat_o.req       = req_q;
  assign stat_o.empty     = cnt_q == '0;
  assign stat_o.lt2       = cnt_q < CW'(2);
  assign stat_o.full      = cnt_q == MaxCnt;
  assign stat_o.walk_end  = hit || last;
  assign stat_o.sqrt_last = iter_q == IterW'(SqrtIter - 1);
  assign stat_o.div_last  = iter_q == IterW'(DivW - 1);

  assign pos_x_o          = ox_q;
  assign pos_y_o          = oy_q;
  assign no_path_o        = onp_q;
  assign path_total_o     = otot_q;
  assign append_refused_o = oref_q;

endmodule

// ===== hw/rtl/polyline_point_at_distance_top.sv =====
// Polyline point-at-distance top level: one request in, one response out.
// Clears and refusals do no arithmetic; appends after the first run a 25-step square root.
// A query walks the segments one at a time, then runs two 50-step divisions.
// One request is in work at a time; a finished response waits in an output register.
// Asynchronous active-low reset empties the path and zeroes the total; stores are not cleared.
module polyline_point_at_distance_top #(
  parameter int unsigned MaxVertices = ppad_pkg::MaxVerticesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppad_req_if.sink   req_i,
  ppad_rsp_if.source rsp_o
);
  import ppad_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ppad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ppad_dp #(
    .MaxVertices (MaxVertices)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (req_i.req_type),
    .vertex_x_i       (req_i.vertex_x),
    .vertex_y_i       (req_i.vertex_y),
    .travelled_i      (req_i.travelled),
    .forward_i        (req_i.forward),
    .pos_x_o          (rsp_o.pos_x),
    .pos_y_o          (rsp_o.pos_y),
    .no_path_o        (rsp_o.no_path),
    .path_total_o     (rsp_o.path_total),
    .append_refused_o (rsp_o.append_refused)
  );

endmodule
